// ----- sv/cpt_pkg.sv -----
// Shared widths, codes and stage payload types for the closest-point pipeline.
// Used by cpt_div, cpt_sqrt and closest_point_on_triangle_top; no dependencies.
`default_nettype none
package cpt_pkg;

	localparam int CW  = 32;           // coordinate width
	localparam int EW  = CW + 1;       // edge / offset vectors
	localparam int PW  = 2 * EW;       // edge component times edge component
	localparam int QW  = PW + 2;       // dot products a..e
	localparam int LW  = QW / 2;       // limb width for wide multiplies
	localparam int PPW = 2 * LW;       // one limb partial product
	localparam int MW  = 2 * QW;       // magnitude of a dot x dot product
	localparam int WW  = MW + 4;       // signed det, sn, tn and friends
	localparam int FB  = 32;           // fraction bits of s and t
	localparam int SW  = FB + 1;       // s and t, 0 up to exactly 1.0
	localparam int CPW = EW + SW + 1;  // edge component times s or t
	localparam int AW  = CPW + 2;      // rounded sum of two such products
	localparam int SQW = PW + 2;       // sum of squared distances
	localparam int RW  = 35;           // square root bits produced
	localparam int TW  = SQW + 2;      // square root trial value
	localparam int DW  = 33;           // distance output
	localparam int RGW = 3;            // region code
	localparam int MDW = 3;            // parameter select code

	// dot product terms
	localparam int NT  = 5;
	localparam int T_A = 0;
	localparam int T_B = 1;
	localparam int T_C = 2;
	localparam int T_D = 3;
	localparam int T_E = 4;

	// wide products: a*c, b*b, b*e, c*d, b*d, a*e
	localparam int NP = 6;
	localparam int PX [NP] = '{T_A, T_B, T_B, T_C, T_B, T_A};
	localparam int PY [NP] = '{T_C, T_B, T_E, T_D, T_D, T_E};

	// regions of the (s, t) plane
	localparam logic [RGW-1:0] RG_INTERIOR = 3'd0;
	localparam logic [RGW-1:0] RG_EDGE_ST  = 3'd1;
	localparam logic [RGW-1:0] RG_VERT_T   = 3'd2;
	localparam logic [RGW-1:0] RG_EDGE_S0  = 3'd3;
	localparam logic [RGW-1:0] RG_VERT_O   = 3'd4;
	localparam logic [RGW-1:0] RG_EDGE_T0  = 3'd5;
	localparam logic [RGW-1:0] RG_VERT_S   = 3'd6;

	// how s and t come out of the two quotients qa, qb
	localparam logic [MDW-1:0] MD_ZERO  = 3'd0;  // s = 0,      t = 0
	localparam logic [MDW-1:0] MD_INNER = 3'd1;  // s = qa,     t = qb
	localparam logic [MDW-1:0] MD_SQ_TC = 3'd2;  // s = qa,     t = 1 - qa
	localparam logic [MDW-1:0] MD_TQ_S0 = 3'd3;  // s = 0,      t = qa
	localparam logic [MDW-1:0] MD_SQ_T0 = 3'd4;  // s = qa,     t = 0
	localparam logic [MDW-1:0] MD_TQ_SC = 3'd5;  // s = 1 - qa, t = qa

	typedef struct packed {
		logic [2:0][CW-1:0] p;
		logic [2:0][CW-1:0] v0;
		logic [2:0][EW-1:0] e0;
		logic [2:0][EW-1:0] e1;
	} geo_t;

	typedef struct packed {
		geo_t           geo;
		logic [RGW-1:0] region;
		logic           degen;
		logic [MDW-1:0] mode;
		logic           fa_force;
		logic           fa_one;
		logic           fb_force;
		logic           fb_one;
	} div_side_t;

	typedef struct packed {
		logic [2:0][CW-1:0] q;
		logic [RGW-1:0]     region;
		logic               degen;
	} sq_side_t;

endpackage
`default_nettype wire

// ----- sv/cpt_div.sv -----
// Two-lane restoring fraction divider, one quotient bit per pipeline stage.
// Depends on cpt_pkg; numerators are below their denominators on entry.
`default_nettype none
module cpt_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_vld,
	input  logic [cpt_pkg::WW-1:0] num_a,
	input  logic [cpt_pkg::WW-1:0] den_a,
	input  logic [cpt_pkg::WW-1:0] num_b,
	input  logic [cpt_pkg::WW-1:0] den_b,
	input  cpt_pkg::div_side_t    side_in,
	output logic                  out_vld,
	output logic [cpt_pkg::FB-1:0] q_a,
	output logic [cpt_pkg::FB-1:0] q_b,
	output cpt_pkg::div_side_t    side_out
);
	import cpt_pkg::*;

	typedef struct packed {
		logic [WW-1:0] rem_a;
		logic [WW-1:0] den_a;
		logic [WW-1:0] rem_b;
		logic [WW-1:0] den_b;
		logic [FB-1:0] q_a;
		logic [FB-1:0] q_b;
		div_side_t     side;
	} dstage_t;

	dstage_t       head;
	dstage_t       dv_s [FB];
	logic [FB-1:0] vld_q;

	function automatic dstage_t dstep(input dstage_t x);
		dstage_t       y;
		logic [WW-1:0] ra;
		logic [WW-1:0] rb;
		y  = x;
		ra = {x.rem_a[WW-2:0], 1'b0};
		rb = {x.rem_b[WW-2:0], 1'b0};
		if (ra >= x.den_a) begin
			y.rem_a = ra - x.den_a;
			y.q_a   = {x.q_a[FB-2:0], 1'b1};
		end else begin
			y.rem_a = ra;
			y.q_a   = {x.q_a[FB-2:0], 1'b0};
		end
		if (rb >= x.den_b) begin
			y.rem_b = rb - x.den_b;
			y.q_b   = {x.q_b[FB-2:0], 1'b1};
		end else begin
			y.rem_b = rb;
			y.q_b   = {x.q_b[FB-2:0], 1'b0};
		end
		return y;
	endfunction

	always_comb begin
		head.rem_a = num_a;
		head.den_a = den_a;
		head.rem_b = num_b;
		head.den_b = den_b;
		head.q_a   = '0;
		head.q_b   = '0;
		head.side  = side_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[FB-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0] <= dstep(head);
			for (int k = 1; k < FB; k++) begin
				dv_s[k] <= dstep(dv_s[k-1]);
			end
		end
	end

	assign out_vld  = vld_q[FB-1];
	assign q_a      = dv_s[FB-1].q_a;
	assign q_b      = dv_s[FB-1].q_b;
	assign side_out = dv_s[FB-1].side;

endmodule
`default_nettype wire

// ----- sv/cpt_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, saturated output.
// Depends on cpt_pkg.
`default_nettype none
module cpt_sqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_vld,
	input  logic [cpt_pkg::SQW-1:0] radicand,
	input  cpt_pkg::sq_side_t      side_in,
	output logic                   out_vld,
	output logic [cpt_pkg::DW-1:0]  root,
	output cpt_pkg::sq_side_t      side_out
);
	import cpt_pkg::*;

	typedef struct packed {
		logic [SQW-1:0] rem;
		logic [RW-1:0]  root;
		sq_side_t       side;
	} rstage_t;

	localparam logic [RW-1:0] ROOT_MAX = RW'({DW{1'b1}});

	rstage_t       head;
	rstage_t       rt_s [RW];
	logic [RW-1:0] vld_q;

	// settle root bit k
	function automatic rstage_t rstep(input rstage_t x, input int k);
		rstage_t       y;
		logic [TW-1:0] trial;
		y     = x;
		trial = (TW'(x.root) << (k + 1)) + (TW'(1) << (2 * k));
		if (TW'(x.rem) >= trial) begin
			y.rem  = x.rem - trial[SQW-1:0];
			y.root = x.root | (RW'(1) << k);
		end
		return y;
	endfunction

	always_comb begin
		head.rem  = radicand;
		head.root = '0;
		head.side = side_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[RW-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_s[0] <= rstep(head, RW - 1);
			for (int j = 1; j < RW; j++) begin
				rt_s[j] <= rstep(rt_s[j-1], RW - 1 - j);
			end
		end
	end

	assign out_vld  = vld_q[RW-1];
	assign root     = (rt_s[RW-1].root > ROOT_MAX) ? {DW{1'b1}} : rt_s[RW-1].root[DW-1:0];
	assign side_out = rt_s[RW-1].side;

endmodule
`default_nettype wire

// ----- sv/closest_point_on_triangle_top.sv -----
// Closest point on a triangle: top level, wide-product front end and output math.
// Depends on cpt_pkg, cpt_div and cpt_sqrt.
// Pipeline: 12 front stages, 32 divider stages, 7 point/distance stages and
//   35 square root stages from input accept to result valid.
// Throughput: one item per cycle; a stalled output freezes the whole pipe.
// Reset: arst_n clears all valid bits at once; payload registers are not reset.
`default_nettype none
module closest_point_on_triangle_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [cpt_pkg::CW-1:0] point_x,
	input  logic signed [cpt_pkg::CW-1:0] point_y,
	input  logic signed [cpt_pkg::CW-1:0] point_z,
	input  logic signed [cpt_pkg::CW-1:0] vert0_x,
	input  logic signed [cpt_pkg::CW-1:0] vert0_y,
	input  logic signed [cpt_pkg::CW-1:0] vert0_z,
	input  logic signed [cpt_pkg::CW-1:0] vert1_x,
	input  logic signed [cpt_pkg::CW-1:0] vert1_y,
	input  logic signed [cpt_pkg::CW-1:0] vert1_z,
	input  logic signed [cpt_pkg::CW-1:0] vert2_x,
	input  logic signed [cpt_pkg::CW-1:0] vert2_y,
	input  logic signed [cpt_pkg::CW-1:0] vert2_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [cpt_pkg::CW-1:0] closest_x,
	output logic signed [cpt_pkg::CW-1:0] closest_y,
	output logic signed [cpt_pkg::CW-1:0] closest_z,
	output logic [cpt_pkg::DW-1:0]        distance,
	output logic [cpt_pkg::RGW-1:0]       region,
	output logic                          degenerate
);
	import cpt_pkg::*;

	localparam int NFS = 12;  // front stages before the divider
	localparam int NBS = 7;   // stages between divider and square root

	localparam logic [SW-1:0]        ST_ONE = {1'b1, {FB{1'b0}}};
	localparam logic signed [AW-1:0] Q_MAX  = AW'((64'sd1 <<< (CW - 1)) - 64'sd1);
	localparam logic signed [AW-1:0] Q_MIN  = AW'(-(64'sd1 <<< (CW - 1)));
	localparam logic [AW-1:0]        RND    = AW'(1) << (FB - 1);

	// The whole pipe advances together; the last stage is the output register.
	logic en;
	assign en       = out_ready | ~out_valid;
	assign in_ready = en;

	logic [NFS-1:0] front_vld_q;
	logic [NBS-1:0] back_vld_q;
	logic           div_vld;

	logic [2:0][CW-1:0] pt_in, v0_in, v1_in, v2_in;
	assign pt_in = {point_z, point_y, point_x};
	assign v0_in = {vert0_z, vert0_y, vert0_x};
	assign v1_in = {vert1_z, vert1_y, vert1_x};
	assign v2_in = {vert2_z, vert2_y, vert2_x};

	// ---------------- front end: quadratic terms, det, sn, tn ----------------
	geo_t geo_s1, geo_s2, geo_s3, geo_s4, geo_s5, geo_s6, geo_s7, geo_s8;
	geo_t geo_s9, geo_s10, geo_s11;
	logic [2:0][EW-1:0] dd_s1;

	logic signed [PW-1:0] prod_s2 [NT][3];
	logic signed [QW-1:0] dot_s3 [NT], dot_s4 [NT], dot_s5 [NT], dot_s6 [NT];
	logic signed [QW-1:0] dot_s7 [NT], dot_s8 [NT], dot_s9 [NT], dot_s10 [NT];
	logic [QW-1:0]        mag_s4 [NT];
	logic [NT-1:0]        neg_s4;
	logic [PPW-1:0]       pp_s5 [NP][4];
	logic [NP-1:0]        sgn_s5, sgn_s6;
	logic [MW-1:0]        mag_s6 [NP];
	logic signed [WW-1:0] wp_s7 [NP];

	logic signed [WW-1:0] det_s8, sn_s8, tn_s8, dn_s8;
	logic signed [WW-1:0] det_s9, sn_s9, tn_s9, dn_s9, snt_s9;
	logic signed [WW-1:0] r2t0_s9, r2t1_s9, r6t0_s9, r6t1_s9;
	logic                 degen_s9, degen_s10, degen_s11;
	logic signed [WW-1:0] det_s10, sn_s10, tn_s10, dn_s10, r2d_s10, r6d_s10;
	logic [RGW-1:0]       region_s10, region_s11;
	logic                 gt2_s10, gt6_s10;
	logic signed [WW-1:0] na_s11, da_s11, nb_s11, db_s11;
	logic [MDW-1:0]       mode_s11;
	logic [WW-1:0]        na_s12, da_s12, nb_s12, db_s12;
	div_side_t            side_s12;

	function automatic logic signed [PW-1:0] smul(input logic [EW-1:0] x,
			input logic [EW-1:0] y);
		return $signed(x) * $signed(y);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_vld_q <= '0;
			back_vld_q  <= '0;
		end else if (en) begin
			front_vld_q <= {front_vld_q[NFS-2:0], in_valid};
			back_vld_q  <= {back_vld_q[NBS-2:0], div_vld};
		end
	end

	// stage 10: region classification (sn + tn against det, signs of sn, tn)
	logic [RGW-1:0] rg_d;
	always_comb begin
		if (snt_s9 <= det_s9) begin
			if (sn_s9 < 0) rg_d = (tn_s9 < 0) ? RG_VERT_O : RG_EDGE_S0;
			else           rg_d = (tn_s9 < 0) ? RG_EDGE_T0 : RG_INTERIOR;
		end else begin
			if (sn_s9 < 0) rg_d = RG_VERT_T;
			else           rg_d = (tn_s9 < 0) ? RG_VERT_S : RG_EDGE_ST;
		end
	end

	// stage 11: pick the quotients each region needs
	logic signed [WW-1:0] na_d, da_d, nb_d, db_d, nege, negd, wa, wc;
	logic [MDW-1:0]       md_d;
	always_comb begin
		nege = -WW'(dot_s10[T_E]);
		negd = -WW'(dot_s10[T_D]);
		wa   = WW'(dot_s10[T_A]);
		wc   = WW'(dot_s10[T_C]);
		na_d = '0;
		da_d = WW'(1);
		nb_d = '0;
		db_d = WW'(1);
		md_d = MD_ZERO;
		if (!degen_s10) begin
			case (region_s10)
				RG_INTERIOR: begin
					md_d = MD_INNER; na_d = sn_s10; da_d = det_s10;
					nb_d = tn_s10; db_d = det_s10;
				end
				RG_EDGE_ST: begin
					md_d = MD_SQ_TC; na_d = r2d_s10; da_d = dn_s10;
				end
				RG_EDGE_S0: begin
					md_d = MD_TQ_S0; na_d = nege; da_d = wc;
				end
				RG_EDGE_T0: begin
					md_d = MD_SQ_T0; na_d = negd; da_d = wa;
				end
				RG_VERT_T: begin
					// clamped -e/c also covers the corner at t = 1
					if (gt2_s10) begin
						md_d = MD_SQ_TC; na_d = r2d_s10; da_d = dn_s10;
					end else begin
						md_d = MD_TQ_S0; na_d = nege; da_d = wc;
					end
				end
				RG_VERT_S: begin
					if (gt6_s10) begin
						md_d = MD_TQ_SC; na_d = r6d_s10; da_d = dn_s10;
					end else begin
						md_d = MD_SQ_T0; na_d = negd; da_d = wa;
					end
				end
				RG_VERT_O: begin
					if (dot_s10[T_E] < 0) begin
						md_d = MD_TQ_S0; na_d = nege; da_d = wc;
					end else begin
						md_d = MD_SQ_T0; na_d = negd; da_d = wa;
					end
				end
				default: md_d = MD_ZERO;
			endcase
		end
	end

	// stage 12: clamp cases settled up front, divider sees num < den only
	logic za, oa, zb, ob;
	always_comb begin
		za = (na_s11 <= 0) || (da_s11 <= 0);
		oa = !za && (na_s11 >= da_s11);
		zb = (nb_s11 <= 0) || (db_s11 <= 0);
		ob = !zb && (nb_s11 >= db_s11);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// S1: edges and offset
			for (int i = 0; i < 3; i++) begin
				geo_s1.p[i]  <= pt_in[i];
				geo_s1.v0[i] <= v0_in[i];
				geo_s1.e0[i] <= EW'($signed(v1_in[i])) - EW'($signed(v0_in[i]));
				geo_s1.e1[i] <= EW'($signed(v2_in[i])) - EW'($signed(v0_in[i]));
				dd_s1[i]     <= EW'($signed(v0_in[i])) - EW'($signed(pt_in[i]));
			end
			// S2: component products
			geo_s2 <= geo_s1;
			for (int i = 0; i < 3; i++) begin
				prod_s2[T_A][i] <= smul(geo_s1.e0[i], geo_s1.e0[i]);
				prod_s2[T_B][i] <= smul(geo_s1.e0[i], geo_s1.e1[i]);
				prod_s2[T_C][i] <= smul(geo_s1.e1[i], geo_s1.e1[i]);
				prod_s2[T_D][i] <= smul(geo_s1.e0[i], dd_s1[i]);
				prod_s2[T_E][i] <= smul(geo_s1.e1[i], dd_s1[i]);
			end
			// S3: dot products a..e
			geo_s3 <= geo_s2;
			for (int k = 0; k < NT; k++) begin
				dot_s3[k] <= QW'(prod_s2[k][0]) + QW'(prod_s2[k][1]) + QW'(prod_s2[k][2]);
			end
			// S4: sign and magnitude for the limb multiplies
			geo_s4 <= geo_s3;
			dot_s4 <= dot_s3;
			for (int k = 0; k < NT; k++) begin
				neg_s4[k] <= dot_s3[k][QW-1];
				mag_s4[k] <= dot_s3[k][QW-1] ? QW'(-dot_s3[k]) : QW'(dot_s3[k]);
			end
			// S5: 34x34 partial products
			geo_s5 <= geo_s4;
			dot_s5 <= dot_s4;
			for (int j = 0; j < NP; j++) begin
				sgn_s5[j]   <= neg_s4[PX[j]] ^ neg_s4[PY[j]];
				pp_s5[j][0] <= mag_s4[PX[j]][LW-1:0]  * mag_s4[PY[j]][LW-1:0];
				pp_s5[j][1] <= mag_s4[PX[j]][LW-1:0]  * mag_s4[PY[j]][QW-1:LW];
				pp_s5[j][2] <= mag_s4[PX[j]][QW-1:LW] * mag_s4[PY[j]][LW-1:0];
				pp_s5[j][3] <= mag_s4[PX[j]][QW-1:LW] * mag_s4[PY[j]][QW-1:LW];
			end
			// S6: assemble magnitudes
			geo_s6 <= geo_s5;
			dot_s6 <= dot_s5;
			sgn_s6 <= sgn_s5;
			for (int j = 0; j < NP; j++) begin
				mag_s6[j] <= MW'(pp_s5[j][0]) + (MW'(pp_s5[j][1]) << LW)
					+ (MW'(pp_s5[j][2]) << LW) + (MW'(pp_s5[j][3]) << (2 * LW));
			end
			// S7: restore signs
			geo_s7 <= geo_s6;
			dot_s7 <= dot_s6;
			for (int j = 0; j < NP; j++) begin
				wp_s7[j] <= sgn_s6[j] ? -$signed(WW'(mag_s6[j])) : $signed(WW'(mag_s6[j]));
			end
			// S8: det, sn, tn and the edge denominator a - 2b + c
			geo_s8 <= geo_s7;
			dot_s8 <= dot_s7;
			det_s8 <= wp_s7[0] - wp_s7[1];
			sn_s8  <= wp_s7[2] - wp_s7[3];
			tn_s8  <= wp_s7[4] - wp_s7[5];
			dn_s8  <= WW'(dot_s7[T_A]) - (WW'(dot_s7[T_B]) <<< 1) + WW'(dot_s7[T_C]);
			// S9: sums feeding the region and edge tests
			geo_s9   <= geo_s8;
			dot_s9   <= dot_s8;
			det_s9   <= det_s8;
			sn_s9    <= sn_s8;
			tn_s9    <= tn_s8;
			dn_s9    <= dn_s8;
			snt_s9   <= sn_s8 + tn_s8;
			degen_s9 <= (det_s8 == 0);
			r2t0_s9  <= WW'(dot_s8[T_B]) + WW'(dot_s8[T_D]);
			r2t1_s9  <= WW'(dot_s8[T_C]) + WW'(dot_s8[T_E]);
			r6t0_s9  <= WW'(dot_s8[T_B]) + WW'(dot_s8[T_E]);
			r6t1_s9  <= WW'(dot_s8[T_A]) + WW'(dot_s8[T_D]);
			// S10
			geo_s10    <= geo_s9;
			dot_s10    <= dot_s9;
			det_s10    <= det_s9;
			sn_s10     <= sn_s9;
			tn_s10     <= tn_s9;
			dn_s10     <= dn_s9;
			degen_s10  <= degen_s9;
			region_s10 <= rg_d;
			gt2_s10    <= r2t1_s9 > r2t0_s9;
			gt6_s10    <= r6t1_s9 > r6t0_s9;
			r2d_s10    <= r2t1_s9 - r2t0_s9;
			r6d_s10    <= r6t1_s9 - r6t0_s9;
			// S11
			geo_s11    <= geo_s10;
			degen_s11  <= degen_s10;
			region_s11 <= region_s10;
			mode_s11   <= md_d;
			na_s11     <= na_d;
			da_s11     <= da_d;
			nb_s11     <= nb_d;
			db_s11     <= db_d;
			// S12
			na_s12            <= (za || oa) ? '0 : na_s11;
			da_s12            <= da_s11;
			nb_s12            <= (zb || ob) ? '0 : nb_s11;
			db_s12            <= db_s11;
			side_s12.geo      <= geo_s11;
			side_s12.region   <= region_s11;
			side_s12.degen    <= degen_s11;
			side_s12.mode     <= mode_s11;
			side_s12.fa_force <= za || oa;
			side_s12.fa_one   <= oa;
			side_s12.fb_force <= zb || ob;
			side_s12.fb_one   <= ob;
		end
	end

	// ---------------- quotients s and t ----------------
	logic [FB-1:0] qa_raw, qb_raw;
	div_side_t     dside;

	cpt_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (front_vld_q[NFS-1]),
		.num_a   (na_s12),
		.den_a   (da_s12),
		.num_b   (nb_s12),
		.den_b   (db_s12),
		.side_in (side_s12),
		.out_vld (div_vld),
		.q_a     (qa_raw),
		.q_b     (qb_raw),
		.side_out(dside)
	);

	// ---------------- closest point and squared distance ----------------
	geo_t                 geo_p1, geo_p2, geo_p3, geo_p4;
	logic [RGW-1:0]       rg_p1, rg_p2, rg_p3, rg_p4, rg_p5, rg_p6, rg_p7;
	logic                 dg_p1, dg_p2, dg_p3, dg_p4, dg_p5, dg_p6, dg_p7;
	logic [SW-1:0]        s_p1, t_p1;
	logic signed [CPW-1:0] cp_p2 [3][2];
	logic signed [AW-1:0] acc_p3 [3];
	logic [2:0][CW-1:0]   q_p4, q_p5, q_p6, q_p7;
	logic signed [EW-1:0] df_p5 [3];
	logic [PW-1:0]        sq_p6 [3];
	logic [SQW-1:0]       sum_p7;

	logic [SW-1:0] qa, qb, s_d, t_d;
	always_comb begin
		qa = dside.fa_force ? (dside.fa_one ? ST_ONE : '0) : {1'b0, qa_raw};
		qb = dside.fb_force ? (dside.fb_one ? ST_ONE : '0) : {1'b0, qb_raw};
		case (dside.mode)
			MD_INNER: begin s_d = qa;          t_d = qb;          end
			MD_SQ_TC: begin s_d = qa;          t_d = ST_ONE - qa; end
			MD_TQ_S0: begin s_d = '0;          t_d = qa;          end
			MD_SQ_T0: begin s_d = qa;          t_d = '0;          end
			MD_TQ_SC: begin s_d = ST_ONE - qa; t_d = qa;          end
			default:  begin s_d = '0;          t_d = '0;          end
		endcase
	end

	// round half up, drop the s/t fraction, add V0, saturate to 32 bits
	logic signed [AW-1:0] pt_sum [3];
	logic [2:0][CW-1:0]   q_d;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pt_sum[i] = (acc_p3[i] >>> FB) + AW'($signed(geo_p3.v0[i]));
			if (pt_sum[i] > Q_MAX)      q_d[i] = Q_MAX[CW-1:0];
			else if (pt_sum[i] < Q_MIN) q_d[i] = Q_MIN[CW-1:0];
			else                        q_d[i] = pt_sum[i][CW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// P1
			geo_p1 <= dside.geo;
			rg_p1  <= dside.region;
			dg_p1  <= dside.degen;
			s_p1   <= s_d;
			t_p1   <= t_d;
			// P2: E0*s and E1*t
			geo_p2 <= geo_p1;
			rg_p2  <= rg_p1;
			dg_p2  <= dg_p1;
			for (int i = 0; i < 3; i++) begin
				cp_p2[i][0] <= $signed(geo_p1.e0[i]) * $signed({1'b0, s_p1});
				cp_p2[i][1] <= $signed(geo_p1.e1[i]) * $signed({1'b0, t_p1});
			end
			// P3
			geo_p3 <= geo_p2;
			rg_p3  <= rg_p2;
			dg_p3  <= dg_p2;
			for (int i = 0; i < 3; i++) begin
				acc_p3[i] <= AW'(cp_p2[i][0]) + AW'(cp_p2[i][1]) + $signed(RND);
			end
			// P4
			geo_p4 <= geo_p3;
			rg_p4  <= rg_p3;
			dg_p4  <= dg_p3;
			q_p4   <= q_d;
			// P5: P - Q
			rg_p5  <= rg_p4;
			dg_p5  <= dg_p4;
			q_p5   <= q_p4;
			for (int i = 0; i < 3; i++) begin
				df_p5[i] <= EW'($signed(geo_p4.p[i])) - EW'($signed(q_p4[i]));
			end
			// P6
			rg_p6 <= rg_p5;
			dg_p6 <= dg_p5;
			q_p6  <= q_p5;
			for (int i = 0; i < 3; i++) begin
				sq_p6[i] <= $signed(df_p5[i]) * $signed(df_p5[i]);
			end
			// P7
			rg_p7  <= rg_p6;
			dg_p7  <= dg_p6;
			q_p7   <= q_p6;
			sum_p7 <= SQW'(sq_p6[0]) + SQW'(sq_p6[1]) + SQW'(sq_p6[2]);
		end
	end

	// ---------------- distance ----------------
	sq_side_t sq_in, sq_out;
	always_comb begin
		sq_in.q      = q_p7;
		sq_in.region = rg_p7;
		sq_in.degen  = dg_p7;
	end

	cpt_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (back_vld_q[NBS-1]),
		.radicand(sum_p7),
		.side_in (sq_in),
		.out_vld (out_valid),
		.root    (distance),
		.side_out(sq_out)
	);

	assign closest_x  = sq_out.q[0];
	assign closest_y  = sq_out.q[1];
	assign closest_z  = sq_out.q[2];
	assign region     = sq_out.region;
	assign degenerate = sq_out.degen;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for closest_point_on_triangle_top: directed and random queries.
// Depends on cpt_pkg and the closest-point RTL; prediction is computed in-bench.
`timescale 1ns / 100ps

typedef logic signed [191:0] wide_t;

typedef struct {
	logic signed [31:0] p[3];
	logic signed [31:0] v0[3];
	logic signed [31:0] v1[3];
	logic signed [31:0] v2[3];
} query_t;

typedef struct {
	logic signed [31:0] cp[3];
	logic [32:0]        dst;
	logic [2:0]         region;
	logic               degen;
} answer_t;

class closest_point_board;
	answer_t answer_q[$];
	int      mismatches;
	int      checked;
	int      region_seen[8];
	int      degen_seen;

	// s, t quotient with 32 fraction bits, clamped to [0, 1]
	function wide_t clamp_quot(wide_t num, wide_t den);
		if (num <= 0 || den <= 0)
			return 0;
		if (num >= den)
			return wide_t'(1) <<< 32;
		return (num <<< 32) / den;
	endfunction

	function answer_t closest_point(query_t q);
		wide_t   e0[3], e1[3], dd[3];
		wide_t   a, b, c, d, e, det, sn, tn, dn, t0, t1, s, t, acc, sum, cand, root, diff;
		wide_t   one;
		answer_t r;
		one = wide_t'(1) <<< 32;
		for (int i = 0; i < 3; i++) begin
			e0[i] = wide_t'(q.v1[i]) - wide_t'(q.v0[i]);
			e1[i] = wide_t'(q.v2[i]) - wide_t'(q.v0[i]);
			dd[i] = wide_t'(q.v0[i]) - wide_t'(q.p[i]);
		end
		a = e0[0]*e0[0] + e0[1]*e0[1] + e0[2]*e0[2];
		b = e0[0]*e1[0] + e0[1]*e1[1] + e0[2]*e1[2];
		c = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
		d = e0[0]*dd[0] + e0[1]*dd[1] + e0[2]*dd[2];
		e = e1[0]*dd[0] + e1[1]*dd[1] + e1[2]*dd[2];
		det = a*c - b*b;
		sn = b*e - c*d;
		tn = b*d - a*e;
		if (sn + tn <= det) begin
			if (sn < 0)
				r.region = (tn < 0) ? cpt_pkg::RG_VERT_O : cpt_pkg::RG_EDGE_S0;
			else
				r.region = (tn < 0) ? cpt_pkg::RG_EDGE_T0 : cpt_pkg::RG_INTERIOR;
		end else begin
			if (sn < 0)
				r.region = cpt_pkg::RG_VERT_T;
			else
				r.region = (tn < 0) ? cpt_pkg::RG_VERT_S : cpt_pkg::RG_EDGE_ST;
		end
		r.degen = (det == 0);
		dn = a - 2*b + c;
		s = 0;
		t = 0;
		if (!r.degen) begin
			case (r.region)
				cpt_pkg::RG_INTERIOR: begin
					s = clamp_quot(sn, det);
					t = clamp_quot(tn, det);
				end
				cpt_pkg::RG_EDGE_ST: begin
					s = clamp_quot((c + e) - (b + d), dn);
					t = one - s;
				end
				cpt_pkg::RG_EDGE_S0: t = clamp_quot(-e, c);
				cpt_pkg::RG_EDGE_T0: s = clamp_quot(-d, a);
				cpt_pkg::RG_VERT_T: begin
					t0 = b + d;
					t1 = c + e;
					if (t1 > t0) begin
						s = clamp_quot(t1 - t0, dn);
						t = one - s;
					end else
						t = (t1 <= 0) ? one : clamp_quot(-e, c);
				end
				cpt_pkg::RG_VERT_S: begin
					t0 = b + e;
					t1 = a + d;
					if (t1 > t0) begin
						t = clamp_quot(t1 - t0, dn);
						s = one - t;
					end else
						s = (t1 <= 0) ? one : clamp_quot(-d, a);
				end
				default: begin
					// origin vertex: the sign of e picks the edge
					if (e < 0)
						t = clamp_quot(-e, c);
					else
						s = clamp_quot(-d, a);
				end
			endcase
		end
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			acc = (e0[i]*s + e1[i]*t + (wide_t'(1) <<< 31)) >>> 32;
			acc = acc + wide_t'(q.v0[i]);
			if (acc > wide_t'(64'sh7FFFFFFF))
				acc = wide_t'(64'sh7FFFFFFF);
			if (acc < -wide_t'(64'sh80000000))
				acc = -wide_t'(64'sh80000000);
			r.cp[i] = acc[31:0];
			diff = wide_t'(q.p[i]) - acc;
			sum = sum + diff*diff;
		end
		root = 0;
		for (int bt = 34; bt >= 0; bt--) begin
			cand = root | (wide_t'(1) <<< bt);
			if (cand*cand <= sum)
				root = cand;
		end
		if (root > wide_t'(64'h1FFFFFFFF))
			root = wide_t'(64'h1FFFFFFFF);
		r.dst = root[32:0];
		return r;
	endfunction

	function void note_query(query_t q);
		answer_t r;
		r = closest_point(q);
		region_seen[r.region]++;
		if (r.degen)
			degen_seen++;
		answer_q.push_back(r);
	endfunction

	function void check_answer(answer_t got);
		answer_t want;
		bit      bad;
		checked++;
		if (answer_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: unexpected result, nothing pending");
			return;
		end
		want = answer_q.pop_front();
		bad = 0;
		for (int i = 0; i < 3; i++)
			if (got.cp[i] !== want.cp[i])
				bad = 1;
		if (got.dst !== want.dst || got.region !== want.region || got.degen !== want.degen)
			bad = 1;
		if (bad) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("ERROR: result %0d mismatch", checked);
				$display("  exp cp=%0d,%0d,%0d dist=%0d region=%0d degen=%0d",
					want.cp[0], want.cp[1], want.cp[2], want.dst, want.region, want.degen);
				$display("  got cp=%0d,%0d,%0d dist=%0d region=%0d degen=%0d",
					got.cp[0], got.cp[1], got.cp[2], got.dst, got.region, got.degen);
			end
		end
	endfunction
endclass

module tb;
	localparam int UNIT      = 65536;   // 1.0 in Q15.16
	localparam int LIMIT     = 300000;  // cycles before the run is declared hung
	localparam int N_RANDOM  = 430;
	localparam int LONG_HOLD = 400;     // receiver stall, well past pipe depth

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] point_x, point_y, point_z;
	logic signed [31:0] vert0_x, vert0_y, vert0_z;
	logic signed [31:0] vert1_x, vert1_y, vert1_z;
	logic signed [31:0] vert2_x, vert2_y, vert2_z;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] closest_x, closest_y, closest_z;
	logic [32:0]        distance;
	logic [2:0]         region;
	logic               degenerate;

	closest_point_board board;
	int                 cycles;
	bit                 quiet;      // no idling on either side near the end
	bit                 hold_req;   // asks the receiver for one long stall
	int                 sent;

	closest_point_on_triangle_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.vert0_x(vert0_x), .vert0_y(vert0_y), .vert0_z(vert0_z),
		.vert1_x(vert1_x), .vert1_y(vert1_y), .vert1_z(vert1_z),
		.vert2_x(vert2_x), .vert2_y(vert2_y), .vert2_z(vert2_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.closest_x(closest_x), .closest_y(closest_y), .closest_z(closest_z),
		.distance(distance), .region(region), .degenerate(degenerate)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				board.answer_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result monitor: sample on the rising edge, ready only changes on the falling one
	always @(posedge clk) begin
		answer_t got;
		if (arst_n && out_valid && out_ready) begin
			got.cp[0]  = closest_x;
			got.cp[1]  = closest_y;
			got.cp[2]  = closest_z;
			got.dst    = distance;
			got.region = region;
			got.degen  = degenerate;
			board.check_answer(got);
		end
	end

	// receiver: random ready bursts, one long hold on request, steady ready when quiet
	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				for (int k = 0; k < LONG_HOLD; k++) begin
					@(negedge clk);
					out_ready <= 1'b0;
				end
				hold_req = 0;
			end else if (quiet) begin
				@(negedge clk);
				out_ready <= 1'b1;
			end else begin
				n = $urandom_range(1, 14);
				// ready more often than not, with occasional stretches of full rate
				if ($urandom_range(0, 2) != 0) begin
					repeat (n) begin
						@(negedge clk);
						out_ready <= 1'b1;
					end
				end else begin
					repeat (n) begin
						@(negedge clk);
						out_ready <= 1'b0;
					end
				end
			end
		end
	end

	// offer one item and hold it until accepted
	task automatic send_query(query_t q);
		@(negedge clk);
		in_valid <= 1'b1;
		point_x <= q.p[0];  point_y <= q.p[1];  point_z <= q.p[2];
		vert0_x <= q.v0[0]; vert0_y <= q.v0[1]; vert0_z <= q.v0[2];
		vert1_x <= q.v1[0]; vert1_y <= q.v1[1]; vert1_z <= q.v1[2];
		vert2_x <= q.v2[0]; vert2_y <= q.v2[1]; vert2_z <= q.v2[2];
		do
			@(posedge clk);
		while (!in_ready);
		board.note_query(q);
		sent++;
	endtask

	task automatic sender_gap();
		int n;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 14);
			repeat (n) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
	endtask

	// stop offering, then wait until every pending result has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.answer_q.size() != 0)
			@(posedge clk);
	endtask

	// triangle (0,0,0) (4,0,0) (0,4,0) in units, point (px, py, pz)
	function automatic query_t unit_tri(int px, int py, int pz);
		query_t q;
		q.p  = '{px * UNIT, py * UNIT, pz * UNIT};
		q.v0 = '{0, 0, 0};
		q.v1 = '{4 * UNIT, 0, 0};
		q.v2 = '{0, 4 * UNIT, 0};
		return q;
	endfunction

	function automatic logic signed [31:0] rand_coord(int span);
		case (span)
			0:       return $urandom;                                   // full range
			1:       return $signed($urandom_range(0, 2000)) - 1000;    // tiny, raw lsbs
			default: return ($signed($urandom_range(0, 200)) - 100) * UNIT
			                + $signed($urandom_range(0, UNIT - 1));
		endcase
	endfunction

	function automatic query_t rand_query();
		query_t q;
		int     span, shape;
		span  = $urandom_range(0, 9) < 3 ? 0 : ($urandom_range(0, 4) == 0 ? 1 : 2);
		shape = $urandom_range(0, 15);
		for (int i = 0; i < 3; i++) begin
			q.p[i]  = rand_coord(span);
			q.v0[i] = rand_coord(span);
			q.v1[i] = rand_coord(span);
			q.v2[i] = rand_coord(span);
		end
		// now and then a degenerate triangle: repeated vertex or collinear; or the point on a vertex
		if (shape == 0)
			q.v2 = q.v1;
		else if (shape == 1)
			q.v1 = q.v0;
		else if (shape == 2)
			for (int i = 0; i < 3; i++)
				q.v2[i] = q.v0[i] + 2 * (q.v1[i] - q.v0[i]);
		else if (shape == 3)
			q.p = q.v1;
		return q;
	endfunction

	initial begin
		query_t q;
		board    = new();
		cycles   = 0;
		quiet    = 0;
		hold_req = 0;
		sent     = 0;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		point_x = 0; point_y = 0; point_z = 0;
		vert0_x = 0; vert0_y = 0; vert0_z = 0;
		vert1_x = 0; vert1_y = 0; vert1_z = 0;
		vert2_x = 0; vert2_y = 0; vert2_z = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: each region on a simple triangle
		send_query(unit_tri(1, 1, 3));    // interior
		send_query(unit_tri(4, 4, 0));    // beyond the hypotenuse
		send_query(unit_tri(-1, 6, 0));   // past the t vertex
		send_query(unit_tri(1, 6, 0));    // t vertex, via the hypotenuse edge
		send_query(unit_tri(-2, 1, 0));   // beyond s = 0 edge
		send_query(unit_tri(-1, -1, 0));  // origin vertex, e >= 0 side
		send_query(unit_tri(-1, -3, 0));  // origin vertex, e >= 0 side
		send_query(unit_tri(1, -2, 0));   // beyond t = 0 edge
		send_query(unit_tri(6, -1, 0));   // past the s vertex
		send_query(unit_tri(6, 1, 0));    // s vertex, via the hypotenuse edge
		send_query(unit_tri(0, 0, 0));    // point on a vertex
		send_query(unit_tri(2, 2, 0));    // point on the hypotenuse
		// degenerate: all vertices equal, then collinear
		q = unit_tri(1, 1, 1);
		q.v1 = q.v0;
		q.v2 = q.v0;
		send_query(q);
		q = unit_tri(3, -2, 5);
		q.v2 = '{8 * UNIT, 0, 0};
		send_query(q);
		// field extremes, then a tiny triangle near the origin
		q.p = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
		q.v0 = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
		q.v1 = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000};
		q.v2 = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000};
		send_query(q);
		q.p = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
		q.v0 = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
		q.v1 = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF};
		q.v2 = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000};
		send_query(q);
		q.p = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000};
		q.v0 = '{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF};
		q.v1 = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000};
		q.v2 = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF};
		send_query(q);
		q.p = '{-1, -1, -1};
		q.v0 = '{0, 0, 0};
		q.v1 = '{1, 0, 0};
		q.v2 = '{0, 0, 1};
		send_query(q);

		// sender pause: let the pipe empty before the random part
		wait_drained();

		for (int k = 0; k < N_RANDOM; k++) begin
			// long receiver hold while items keep coming, so the pipe backs up
			if (k == 120)
				hold_req = 1;
			if (k == 260)
				wait_drained();
			if (k == N_RANDOM - 80)
				quiet = 1;
			send_query(rand_query());
			if (k < 120 || k > 250)
				sender_gap();
		end
		@(negedge clk);
		in_valid <= 1'b0;

		wait_drained();
		repeat (120) @(posedge clk);

		$display("%0d queries, %0d results checked, %0d degenerate triangles", sent,
			board.checked, board.degen_seen);
		$display("regions hit: %0d %0d %0d %0d %0d %0d %0d", board.region_seen[0],
			board.region_seen[1], board.region_seen[2], board.region_seen[3],
			board.region_seen[4], board.region_seen[5], board.region_seen[6]);
		if (board.mismatches == 0 && board.answer_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
